[sv/kci_pkg.sv]
// kci_pkg: shared types, widths and constants for the knot curve interpolator
// used by kci_div, kci_front, kci_back and knot_curve_interpolator
// no dependencies
`default_nettype none

package kci_pkg;

	// field widths
	localparam int KNOT_INDEX_W = 5;
	localparam int POS_W        = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 6;
	localparam int DIVISOR_W    = 32;
	localparam int FRAC_W       = 16;

	// table size default
	localparam int MAX_KNOTS_DEF = 32;

	// configuration registers
	localparam int REG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_KNOT_COUNT = 1'b0,
		REG_DIVISOR    = 1'b1
	} reg_idx_t;

	localparam logic [COUNT_W-1:0]   KNOT_COUNT_RST = 6'd2;
	localparam logic [DIVISOR_W-1:0] DIVISOR_RST    = 32'h0001_0000;

	// arithmetic widths
	localparam int PROD_W      = VALUE_W + POS_W;       // value times position delta
	localparam int DIVIDEND_W  = PROD_W + FRAC_W + 1;   // num * 2^16 + q/2
	localparam int DIV_STEPS   = DIVIDEND_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	// queue between front and back, power of two
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OUTSIDE   = 2'd1,
		STATUS_SATURATED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SKIP  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef struct packed {
		logic                    mode;
		logic [KNOT_INDEX_W-1:0] knot_index;
		logic [POS_W-1:0]        knot_position;
		logic [VALUE_W-1:0]      knot_value;
		logic [POS_W-1:0]        frequency;
		logic                    last_in;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] curve_value;
		status_t            status;
		logic               last_out;
	} result_t;

	typedef struct packed {
		op_t                     op;
		logic [KNOT_INDEX_W-1:0] knot_index;
		logic [POS_W-1:0]        knot_position;
		logic [VALUE_W-1:0]      knot_value;
		logic [POS_W-1:0]        frequency;
		logic                    last_in;
	} queue_entry_t;

	// 32 x 16 unsigned product
	function automatic logic [PROD_W-1:0] mul_vp(input logic [VALUE_W-1:0] a,
		input logic [POS_W-1:0] b);
		mul_vp = {{POS_W{1'b0}}, a} * {{VALUE_W{1'b0}}, b};
	endfunction

endpackage

`default_nettype wire

[sv/kci_div.sv]
// kci_div: restoring divider, one quotient bit per cycle, flags a quotient that overflows 32 bits
// depends on kci_pkg
`default_nettype none

module kci_div
	import kci_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [PROD_W-1:0]     divisor,
	output logic                       valid,
	output logic [VALUE_W-1:0]         quotient,
	output logic                       overflow
);

	logic                  running_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  valid_q;
	logic [DIVIDEND_W-1:0] dividend_q;
	logic [PROD_W-1:0]     divisor_q;
	logic [PROD_W-1:0]     rem_q;
	logic [VALUE_W-1:0]    quo_q;
	logic                  ovf_q;

	logic [PROD_W:0] trial;
	logic [PROD_W:0] diff;
	logic            ge;

	always_comb begin
		trial = {rem_q, dividend_q[DIVIDEND_W-1]};
		ge    = (trial >= {1'b0, divisor_q});
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= DIV_CNT_W'(DIV_STEPS);
			end else if (running_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					running_q <= 1'b0;
					valid_q   <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
			quo_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (running_q) begin
			dividend_q <= {dividend_q[DIVIDEND_W-2:0], 1'b0};
			rem_q      <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
			// any one pushed past bit 31 means the quotient does not fit
			ovf_q      <= ovf_q | quo_q[VALUE_W-1];
			quo_q      <= {quo_q[VALUE_W-2:0], ge};
		end
	end

	assign valid    = valid_q;
	assign quotient = quo_q;
	assign overflow = ovf_q;

endmodule

`default_nettype wire

[sv/kci_front.sv]
// kci_front: accepts transactions, classifies them and holds them in a short queue
// depends on kci_pkg
`default_nettype none

module kci_front
	import kci_pkg::*;
#(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire in_item_t item,
	output logic          busy,
	output queue_entry_t  head,
	output logic          head_valid,
	input  wire logic     pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t     q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	queue_entry_t     entry_c;

	// classify: query, load in range, or load that falls off the table
	always_comb begin
		entry_c.knot_index    = item.knot_index;
		entry_c.knot_position = item.knot_position;
		entry_c.knot_value    = item.knot_value;
		entry_c.frequency     = item.frequency;
		entry_c.last_in       = item.last_in;
		if (item.mode) begin
			entry_c.op = OP_QUERY;
		end else if (32'(item.knot_index) < 32'(MAX_KNOTS)) begin
			entry_c.op = OP_LOAD;
		end else begin
			entry_c.op = OP_SKIP;
		end
	end

	assign busy       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= entry_c;
		end
	end

endmodule

`default_nettype wire

[sv/kci_back.sv]
// kci_back: knot tables, sequential knot search, interpolation products and divide
// depends on kci_pkg and kci_div
`default_nettype none

module kci_back
	import kci_pkg::*;
#(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [COUNT_W-1:0]   knot_count,
	input  wire logic [DIVISOR_W-1:0] divisor,
	input  wire queue_entry_t         head,
	input  wire logic                 head_valid,
	output logic                      pop,
	output result_t                   result,
	output logic                      done
);

	localparam int AW = $clog2(MAX_KNOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_SUM,
		ST_DIV
	} state_t;

	state_t state_q;

	// knot tables, undefined until written
	logic [POS_W-1:0]   pos_mem [MAX_KNOTS];
	logic [VALUE_W-1:0] val_mem [MAX_KNOTS];
	logic [POS_W-1:0]   rd_pos_q;
	logic [VALUE_W-1:0] rd_val_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;

	logic [AW-1:0]        k_q;
	logic [AW-1:0]        last_k;
	logic [POS_W-1:0]     freq_q;
	logic                 last_q;
	logic [POS_W-1:0]     prev_pos_q;
	logic [VALUE_W-1:0]   prev_val_q;
	logic [VALUE_W-1:0]   mv0_q;
	logic [POS_W-1:0]     mf0_q;
	logic [VALUE_W-1:0]   mv1_q;
	logic [POS_W-1:0]     mf1_q;
	logic [POS_W-1:0]     dp_q;
	logic [PROD_W-1:0]    prod0_q;
	logic [PROD_W-1:0]    prod1_q;
	logic [PROD_W-1:0]    qprod_q;
	logic [DIVISOR_W-1:0] div_eff;
	result_t              result_q;
	logic                 done_q;

	logic [PROD_W:0]       num_sum;
	logic [DIVIDEND_W-1:0] dividend;
	logic                  div_start;
	logic                  div_valid;
	logic [VALUE_W-1:0]    div_quo;
	logic                  div_ovf;

	// last knot index in use, count clamped into 2..MAX_KNOTS
	always_comb begin
		int unsigned cnt;
		cnt = 32'(knot_count);
		if (cnt < 32'd2) begin
			cnt = 32'd2;
		end
		if (cnt > 32'(MAX_KNOTS)) begin
			cnt = 32'(MAX_KNOTS);
		end
		last_k = AW'(cnt - 32'd1);
	end

	assign div_eff = (divisor == '0) ? DIVISOR_W'(1) : divisor;

	assign pop     = (state_q == ST_IDLE) && head_valid;
	assign mem_we  = pop && (head.op == OP_LOAD);
	assign rd_addr = (state_q == ST_SCAN) ? (k_q + AW'(1)) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pos_mem[AW'(head.knot_index)] <= head.knot_position;
			val_mem[AW'(head.knot_index)] <= head.knot_value;
		end
		rd_pos_q <= pos_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	// num * 2^16 + q/2, num fits in PROD_W bits
	always_comb begin
		num_sum  = {1'b0, prod0_q} + {1'b0, prod1_q};
		dividend = {1'b0, num_sum[PROD_W-1:0], {FRAC_W{1'b0}}}
			+ DIVIDEND_W'(qprod_q >> 1);
	end

	assign div_start = (state_q == ST_SUM);

	kci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (qprod_q),
		.valid    (div_valid),
		.quotient (div_quo),
		.overflow (div_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			result_q   <= '0;
			k_q        <= '0;
			freq_q     <= '0;
			last_q     <= 1'b0;
			prev_pos_q <= '0;
			prev_val_q <= '0;
			mv0_q      <= '0;
			mf0_q      <= '0;
			mv1_q      <= '0;
			mf1_q      <= '0;
			dp_q       <= '0;
			prod0_q    <= '0;
			prod1_q    <= '0;
			qprod_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (head.op == OP_QUERY)) begin
						freq_q  <= head.frequency;
						last_q  <= head.last_in;
						k_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_pos_q >= freq_q) begin
						if (rd_pos_q == freq_q) begin
							// exact hit: value over divisor alone
							mv0_q   <= rd_val_q;
							mf0_q   <= POS_W'(1);
							mv1_q   <= '0;
							mf1_q   <= '0;
							dp_q    <= POS_W'(1);
							state_q <= ST_MUL;
						end else if (k_q == '0) begin
							result_q.curve_value <= '0;
							result_q.status      <= STATUS_OUTSIDE;
							result_q.last_out    <= last_q;
							done_q               <= 1'b1;
							state_q              <= ST_IDLE;
						end else begin
							mv0_q   <= prev_val_q;
							mf0_q   <= rd_pos_q - freq_q;
							mv1_q   <= rd_val_q;
							mf1_q   <= freq_q - prev_pos_q;
							dp_q    <= rd_pos_q - prev_pos_q;
							state_q <= ST_MUL;
						end
					end else if (k_q == last_k) begin
						result_q.curve_value <= '0;
						result_q.status      <= STATUS_OUTSIDE;
						result_q.last_out    <= last_q;
						done_q               <= 1'b1;
						state_q              <= ST_IDLE;
					end else begin
						k_q        <= k_q + AW'(1);
						prev_pos_q <= rd_pos_q;
						prev_val_q <= rd_val_q;
					end
				end
				ST_MUL: begin
					prod0_q <= mul_vp(mv0_q, mf0_q);
					prod1_q <= mul_vp(mv1_q, mf1_q);
					qprod_q <= mul_vp(div_eff, dp_q);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_valid) begin
						result_q.curve_value <= div_ovf ? '1 : div_quo;
						result_q.status      <= div_ovf ? STATUS_SATURATED : STATUS_OK;
						result_q.last_out    <= last_q;
						done_q               <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

[sv/knot_curve_interpolator.sv]
// knot_curve_interpolator: piecewise linear curve over a table of knots
// depends on kci_pkg, kci_front, kci_back (which holds kci_div)
// a query leaving the queue scans the knots, one per cycle from the table
//   port; one that falls outside ends there, the rest go on to the products,
//   a 65-step divider and the output
// a load is written as it leaves the queue, a query holds the back end until
//   its result is out; the two-entry queue takes transactions until full
// reset: asynchronous, active low; empties the queue, sets knot_count to 2 and
//   divisor to 1.0; the knot tables hold garbage until loaded
// results appear for one cycle on done, the receiver cannot stall them
`default_nettype none

module knot_curve_interpolator
	import kci_pkg::*;
#(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire in_item_t              item,
	// result side
	output logic                       done,
	output result_t                    result,
	// configuration writes
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	logic [COUNT_W-1:0]   knot_count_q;
	logic [DIVISOR_W-1:0] divisor_q;

	queue_entry_t head;
	logic         head_valid;
	logic         pop;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= KNOT_COUNT_RST;
			divisor_q    <= DIVISOR_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_KNOT_COUNT: knot_count_q <= wr_data[COUNT_W-1:0];
				REG_DIVISOR:    divisor_q    <= wr_data[DIVISOR_W-1:0];
				default:        ;
			endcase
		end
	end

	// front: takes a transaction whenever the queue has room and tags it
	// as a query, a table load, or a load past the end of the table
	kci_front #(
		.MAX_KNOTS (MAX_KNOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back: writes loads into the tables, walks the knots for a query,
	// forms the interpolation products and runs the rounding divide
	kci_back #(
		.MAX_KNOTS (MAX_KNOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.knot_count (knot_count_q),
		.divisor    (divisor_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result),
		.done       (done)
	);

endmodule

`default_nettype wire

[sim/knot_curve_interpolator_tb.sv]
// knot_curve_interpolator_tb: self-checking bench for the knot curve interpolator,
// directed table of loads, queries and register writes, then random phases
// depends on kci_pkg and knot_curve_interpolator
module knot_curve_interpolator_tb;
	import kci_pkg::*;

	// drain wait after the last result: a query scans up to 32 knots, and loads
	// may still sit in the two-entry queue behind it
	localparam int DRAIN_CYCLES = 150;
	// longest legal quiet stretch is a drain plus one slow query plus a gap;
	// allow several times that
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 153;
	localparam int PHASES       = 9;
	localparam int MAX_PRINTS   = 40;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t   kind;
		in_item_t    it;
		bit          typed;
		result_t     want;
		reg_idx_t    sel;
		logic [31:0] data;
	} dir_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic                  busy;
	in_item_t              item     = '0;
	logic                  done;
	result_t               result;
	logic                  wr_en    = 1'b0;
	reg_idx_t              wr_index = REG_KNOT_COUNT;
	logic [CFG_DATA_W-1:0] wr_data  = '0;

	// mirror of the block state
	logic [POS_W-1:0]     tb_pos [MAX_KNOTS_DEF];
	logic [VALUE_W-1:0]   tb_val [MAX_KNOTS_DEF];
	logic [COUNT_W-1:0]   cur_count   = KNOT_COUNT_RST;
	logic [DIVISOR_W-1:0] cur_divisor = DIVISOR_RST;

	// results still owed by the block, oldest first
	result_t  pending_curve [$];
	dir_row_t dir_rows [$];

	int err_count   = 0;
	int n_results   = 0;
	int n_ok        = 0;
	int n_outside   = 0;
	int n_sat       = 0;
	int n_loads     = 0;
	int n_queries   = 0;
	int n_writes    = 0;
	int n_holds     = 0;
	int stall_count = 0;

	knot_curve_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// count of knots the search really walks
	function automatic int active_knots();
		int n;
		n = cur_count;
		if (n < 2) n = 2;
		if (n > MAX_KNOTS_DEF) n = MAX_KNOTS_DEF;
		return n;
	endfunction

	// expected curve value for one query against the mirrored table
	function automatic result_t curve_at(input logic [POS_W-1:0] freq, input logic last);
		result_t          r;
		int               n;
		int               k;
		logic [64:0]      num;
		logic [64:0]      q;
		logic [64:0]      quo;
		logic [64:0]      d;
		logic [POS_W-1:0] p0;
		logic [POS_W-1:0] p1;
		n = active_knots();
		// a zero divisor behaves as the smallest step
		d = (cur_divisor == '0) ? 65'd1 : 65'(cur_divisor);
		r.last_out    = last;
		r.curve_value = '0;
		r.status      = STATUS_OUTSIDE;
		k = 0;
		while (k < n && tb_pos[k] < freq) k++;
		// above the last knot, or under the first one without a hit: outside
		if (k < n && (tb_pos[k] == freq || k != 0)) begin
			if (tb_pos[k] == freq) begin
				num = 65'(tb_val[k]);
				q   = d;
			end else begin
				p0  = tb_pos[k-1];
				p1  = tb_pos[k];
				num = 65'(tb_val[k-1]) * 65'(p1 - freq) + 65'(tb_val[k]) * 65'(freq - p0);
				q   = 65'(p1 - p0) * d;
			end
			// round to nearest, ties up, once
			quo = ((num << FRAC_W) + (q >> 1)) / q;
			if (quo > 65'hFFFF_FFFF) begin
				r.curve_value = '1;
				r.status      = STATUS_SATURATED;
			end else begin
				r.curve_value = quo[31:0];
				r.status      = STATUS_OK;
			end
		end
		return r;
	endfunction

	// item with every field random, the caller sets what matters
	function automatic in_item_t noise_item();
		in_item_t it;
		it.mode          = 1'($urandom_range(0, 1));
		it.knot_index    = 5'($urandom_range(0, 31));
		it.knot_position = 16'($urandom_range(0, 16'hFFFF));
		it.knot_value    = $urandom;
		it.frequency     = 16'($urandom_range(0, 16'hFFFF));
		it.last_in       = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch at result %0d: %s got %h want %h", n_results, what, got, want);
		err_count++;
	endtask

	// drive one transaction from a falling edge and hold it until taken
	task automatic issue(input in_item_t it, input bit typed, input result_t want);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (it.mode == MODE_LOAD) begin
			tb_pos[it.knot_index] = it.knot_position;
			tb_val[it.knot_index] = it.knot_value;
			n_loads++;
		end else begin
			pending_curve.push_back(typed ? want : curve_at(it.frequency, it.last_in));
			n_queries++;
		end
		@(negedge clk);
	endtask

	// sender idling between transactions; now and then wait out every result
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 299) == 0) begin
			start <= 1'b0;
			@(negedge clk);
			while (pending_curve.size() != 0) @(negedge clk);
			n_holds++;
		end else begin
			// each cycle idles with the given chance
			while ($urandom_range(0, 99) < pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
	endtask

	// block idle: nothing owed, and loads that give no result have drained
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending_curve.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		n_holds++;
	endtask

	task automatic write_reg(input reg_idx_t sel, input logic [31:0] data);
		wr_en    <= 1'b1;
		wr_index <= sel;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (sel == REG_KNOT_COUNT) cur_count = data[COUNT_W-1:0];
		else cur_divisor = data;
		n_writes++;
		@(negedge clk);
	endtask

	// well-formed table: ascending positions over the first n slots
	task automatic load_ramp(input int n, input int pct);
		in_item_t it;
		int       step_max;
		int       p;
		step_max = 65536 / n;
		p = $urandom_range(0, step_max / 2);
		for (int i = 0; i < n; i++) begin
			it            = noise_item();
			it.mode       = MODE_LOAD;
			it.knot_index = 5'(i);
			it.knot_position = (p > 32768) ? 16'd32768 : 16'(p);
			case ($urandom_range(0, 9))
				0: it.knot_value = '0;
				1: it.knot_value = '1;
				default: it.knot_value = $urandom;
			endcase
			issue(it, 1'b0, '0);
			sender_gap(pct);
			p += $urandom_range(0, step_max);
		end
	endtask

	task automatic dir_load(input int idx, input int pos, input logic [31:0] val);
		dir_row_t row;
		row.kind             = ROW_ITEM;
		row.it               = noise_item();
		row.it.mode          = MODE_LOAD;
		row.it.knot_index    = 5'(idx);
		row.it.knot_position = 16'(pos);
		row.it.knot_value    = val;
		row.typed            = 1'b0;
		row.want             = '0;
		row.sel              = REG_KNOT_COUNT;
		row.data             = '0;
		dir_rows.push_back(row);
	endtask

	// typed rows carry their answer, the rest go through curve_at
	task automatic dir_query(input int freq, input logic last, input bit typed,
		input logic [31:0] val, input status_t st);
		dir_row_t row;
		row.kind                 = ROW_ITEM;
		row.it                   = noise_item();
		row.it.mode              = MODE_QUERY;
		row.it.frequency         = 16'(freq);
		row.it.last_in           = last;
		row.typed                = typed;
		row.want.curve_value     = val;
		row.want.status          = st;
		row.want.last_out        = last;
		row.sel                  = REG_KNOT_COUNT;
		row.data                 = '0;
		dir_rows.push_back(row);
	endtask

	task automatic dir_write(input reg_idx_t sel, input logic [31:0] data);
		dir_row_t row;
		row.kind  = ROW_WRITE;
		row.it    = '0;
		row.typed = 1'b0;
		row.want  = '0;
		row.sel   = sel;
		row.data  = data;
		dir_rows.push_back(row);
	endtask

	// result checker: every strobe must match the oldest owed result
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_curve.size() == 0) begin
				report_mismatch("unexpected transaction, value", result.curve_value, '0);
			end else begin
				want = pending_curve.pop_front();
				if (result.curve_value !== want.curve_value)
					report_mismatch("curve_value", result.curve_value, want.curve_value);
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.last_out !== want.last_out)
					report_mismatch("last_out", 32'(result.last_out), 32'(want.last_out));
				case (want.status)
					STATUS_OK:        n_ok++;
					STATUS_OUTSIDE:   n_outside++;
					default:          n_sat++;
				endcase
			end
			n_results++;
		end
	end

	// watchdog: quiet cycles with neither side moving a transaction
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_count = 0;
		else stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", stall_count);
			$display("knot_curve_interpolator_tb NOT OK");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		int       pct;
		int       phase_items;
		int       n;
		int       k;
		int       cnt;
		logic [31:0] dv;

		for (int i = 0; i < MAX_KNOTS_DEF; i++) begin
			tb_pos[i] = '0;
			tb_val[i] = '0;
		end

		// after reset: two knots in use, divisor 1.0, so hits return the value itself
		dir_load(0, 16'h1000, 32'h0002_0000);
		dir_load(1, 16'h8000, 32'hFFFF_FFFF);
		dir_query(16'h1000, 1'b0, 1'b1, 32'h0002_0000, STATUS_OK);
		dir_query(16'h8000, 1'b1, 1'b1, 32'hFFFF_FFFF, STATUS_OK);
		// below the first knot, just below it, and past the last
		dir_query(16'h0000, 1'b0, 1'b1, 32'h0, STATUS_OUTSIDE);
		dir_query(16'h0FFF, 1'b1, 1'b1, 32'h0, STATUS_OUTSIDE);
		dir_query(16'hFFFF, 1'b1, 1'b1, 32'h0, STATUS_OUTSIDE);
		dir_query(16'h4000, 1'b0, 1'b0, 32'h0, STATUS_OK);
		// tiny divisor overflows the value
		dir_write(REG_DIVISOR, 32'd1);
		dir_query(16'h1000, 1'b0, 1'b1, 32'hFFFF_FFFF, STATUS_SATURATED);
		// zero divisor behaves like one
		dir_write(REG_DIVISOR, 32'd0);
		dir_query(16'h1000, 1'b1, 1'b1, 32'hFFFF_FFFF, STATUS_SATURATED);
		dir_query(16'h1001, 1'b0, 1'b0, 32'h0, STATUS_OK);
		// largest divisor brings full scale down to 1.0
		dir_write(REG_DIVISOR, 32'hFFFF_FFFF);
		dir_query(16'h8000, 1'b0, 1'b1, 32'h0001_0000, STATUS_OK);
		// knot count of zero clamps up to two
		dir_write(REG_KNOT_COUNT, 32'd0);
		dir_query(16'h8000, 1'b1, 1'b1, 32'h0001_0000, STATUS_OK);
		// third knot out of order: search runs past it, or stops at the first
		dir_load(2, 16'h0800, 32'h1234_5678);
		dir_load(31, 16'hFFFF, 32'h0);
		dir_write(REG_KNOT_COUNT, 32'd3);
		dir_query(16'h9000, 1'b0, 1'b1, 32'h0, STATUS_OUTSIDE);
		dir_query(16'h0900, 1'b1, 1'b1, 32'h0, STATUS_OUTSIDE);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: items back to back with no idling, writes only after a settle
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].sel, dir_rows[i].data);
			end else begin
				issue(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases, each under its own register setting; the first fills
		// all 32 slots so no query ever reads an unwritten knot
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin cnt = 32;                     dv = 32'h0001_0000; end
				1: begin cnt = 63;                     dv = 32'hFFFF_FFFF; end
				2: begin cnt = 2;                      dv = 32'd1;         end
				3: begin cnt = 1;                      dv = 32'd0;         end
				4: begin cnt = 17;                     dv = $urandom;      end
				5: begin cnt = 33;                     dv = 32'd256;       end
				6: begin cnt = $urandom_range(0, 63);  dv = $urandom;      end
				7: begin cnt = 5;                      dv = 32'h8000_0000; end
				default: begin cnt = 12;               dv = 32'h0001_8000; end
			endcase
			// sender idling: a third of the time, then about half, then none
			pct = (p < 3) ? 34 : (p < 6) ? 53 : 0;
			settle();
			write_reg(REG_KNOT_COUNT, 32'(cnt));
			write_reg(REG_DIVISOR, dv);
			n = active_knots();
			load_ramp((p == 0) ? MAX_KNOTS_DEF : n, pct);
			phase_items = n;
			while (phase_items < PHASE_ITEMS) begin
				k = $urandom_range(0, 99);
				if (k < 4) begin
					// fresh ordered table with new content
					load_ramp(n, pct);
					phase_items += n;
				end else if (k < 12) begin
					// stray load: any slot, any position, may break the order
					it      = noise_item();
					it.mode = MODE_LOAD;
					issue(it, 1'b0, '0);
					sender_gap(pct);
					phase_items++;
				end else begin
					it      = noise_item();
					it.mode = MODE_QUERY;
					k       = $urandom_range(1, n - 1);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: it.frequency = 16'($urandom_range(tb_pos[k-1], tb_pos[k]));
						4:          it.frequency = tb_pos[k];
						5:          it.frequency = tb_pos[0];
						6:          it.frequency = 16'($urandom_range(0, tb_pos[0]));
						7:          it.frequency = 16'($urandom_range(tb_pos[n-1], 16'hFFFF));
						default:    it.frequency = 16'($urandom_range(0, 16'hFFFF));
					endcase
					issue(it, 1'b0, '0);
					sender_gap(pct);
					phase_items++;
				end
			end
		end

		// wind down: all results in, then a latency's worth of quiet
		start <= 1'b0;
		while (pending_curve.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_curve.size() != 0)
			report_mismatch("results never came, count", 32'(pending_curve.size()), '0);

		$display("ran %0d loads and %0d queries over %0d register writes, %0d drain holds",
			n_loads, n_queries, n_writes, n_holds);
		$display("checked %0d results: %0d ok, %0d outside, %0d saturated, %0d mismatches",
			n_results, n_ok, n_outside, n_sat, err_count);
		if (err_count == 0) begin
			$display("knot_curve_interpolator_tb OK");
		end else begin
			$display("knot_curve_interpolator_tb NOT OK");
		end
		$finish;
	end

endmodule

[sim.f]
sv/kci_pkg.sv
sv/kci_div.sv
sv/kci_front.sv
sv/kci_back.sv
sv/knot_curve_interpolator.sv
sim/knot_curve_interpolator_tb.sv
